@@ rtl/open_zone_mru_tracker_macros.svh @@
// Assertion macros shared by the open zone MRU tracker checker
`ifndef OPEN_ZONE_MRU_TRACKER_MACROS_SVH
`define OPEN_ZONE_MRU_TRACKER_MACROS_SVH

// Same-cycle implication, sampled on clk and held off during rst
`define OZM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ozm check failed: same-cycle rule");

// Next-cycle implication, sampled on clk and held off during rst
`define OZM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ozm check failed: next-cycle rule");

`endif

@@ rtl/ozm_pkg.sv @@
// Types and constants for the open zone MRU tracker
package ozm_pkg;

  localparam int IN_DATA_BITS  = 16;
  localparam int POS_BITS      = 3;
  localparam int COUNT_BITS    = 32;
  localparam int OUT_DATA_BITS = 40;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Match state handed from one cell to the next, front of the list first
  typedef struct packed {
    logic                hit;
    logic [POS_BITS-1:0] pos;
  } ozm_link_t;

endpackage

@@ rtl/open_zone_mru_tracker.sv @@
// Top level of the open zone MRU tracker: a row of list cells and the result register
//
//  channel  dir  beat contents (low bits first)
//  s_*      in   tdata[15:0] zone_id
//  m_*      out  tdata[0] hit, [3:1] hit_position, [35:4] opened_count, [39:36] zero
//
// One beat per cycle unless the result stalls: compare, forward match chain through
// the cells and shift settle in the accepting cycle; the result shows the cycle after.
// Input is taken whenever the result register is empty or being emptied.
// rst empties the list (valid bits only), zeroes the count and drops the result.
// A stalled result holds the list still; nothing is lost or repeated.
module open_zone_mru_tracker #(
  parameter int MAX_OPEN_ZONES = 8,
  parameter int ZONE_ID_BITS   = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [ozm_pkg::IN_DATA_BITS-1:0]   s_tdata,   // zone_id
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [ozm_pkg::OUT_DATA_BITS-1:0]  m_tdata    // hit, hit_position, opened_count
);
  import ozm_pkg::*;

  localparam int KEEP_BITS = (ZONE_ID_BITS < IN_DATA_BITS) ? ZONE_ID_BITS : IN_DATA_BITS;

  logic                    step;
  logic [ZONE_ID_BITS-1:0] id;
  logic [ZONE_ID_BITS-1:0] entries [MAX_OPEN_ZONES+1];
  logic                    valids  [MAX_OPEN_ZONES+1];
  ozm_link_t               links   [MAX_OPEN_ZONES+1];
  logic [COUNT_BITS-1:0]   opened_total;
  logic [COUNT_BITS-1:0]   opened_total_next;
  logic                    out_hit;
  logic [POS_BITS-1:0]     out_pos;
  logic [COUNT_BITS-1:0]   out_count;

  assign s_tready = !m_tvalid || m_tready;
  assign step     = s_tvalid && s_tready;
  assign id       = ZONE_ID_BITS'(s_tdata[KEEP_BITS-1:0]);

  // Front of the chain: the new id enters slot 0 as valid
  assign entries[0] = id;
  assign valids[0]  = 1'b1;
  assign links[0]   = '0;

  for (genvar p = 0; p < MAX_OPEN_ZONES; p++) begin : g_cell
    ozm_cell #(
      .ID_BITS (ZONE_ID_BITS),
      .POS     (p)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .step       (step),
      .id         (id),
      .prev_entry (entries[p]),
      .prev_valid (valids[p]),
      .link_in    (links[p]),
      .link_out   (links[p+1]),
      .entry      (entries[p+1]),
      .valid      (valids[p+1])
    );
  end

  // Count grows on a miss, stops at its top
  assign opened_total_next = (links[MAX_OPEN_ZONES].hit || opened_total == COUNT_MAX) ?
                             opened_total : opened_total + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      opened_total <= '0;
    end else if (step) begin
      opened_total <= opened_total_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_hit   <= links[MAX_OPEN_ZONES].hit;
      out_pos   <= links[MAX_OPEN_ZONES].pos;
      out_count <= opened_total_next;
    end
  end

  assign m_tdata = OUT_DATA_BITS'({out_count, out_pos, out_hit});

endmodule

@@ rtl/ozm_cell.sv @@
// One list slot: holds a zone id and its valid bit, compares and shifts
module ozm_cell #(
  parameter int ID_BITS = 16,
  parameter int POS     = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [ID_BITS-1:0]  id,
  input  logic [ID_BITS-1:0]  prev_entry,
  input  logic                prev_valid,
  input  ozm_pkg::ozm_link_t  link_in,
  output ozm_pkg::ozm_link_t  link_out,
  output logic [ID_BITS-1:0]  entry,
  output logic                valid
);
  import ozm_pkg::*;

  logic match;

  // Compare against the broadcast id; the first match ahead keeps priority
  assign match         = valid && (entry == id);
  assign link_out.hit  = link_in.hit | match;
  assign link_out.pos  = link_in.hit ? link_in.pos :
                         (match ? POS_BITS'(POS) : '0);

  // Take the neighbour's entry unless the id was found further forward
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (step && !link_in.hit) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && !link_in.hit) begin
      entry <= prev_entry;
    end
  end

endmodule

@@ rtl/ozm_checker.sv @@
// Port-level checks for the open zone MRU tracker, bound to the top level
`include "open_zone_mru_tracker_macros.svh"

module ozm_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tvalid,
  input logic                               s_tready,
  input logic [ozm_pkg::IN_DATA_BITS-1:0]   s_tdata,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [ozm_pkg::OUT_DATA_BITS-1:0]  m_tdata
);
  import ozm_pkg::*;

  // A stalled result beat holds
  `OZM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  // Every accepted beat gives a result next cycle
  `OZM_ASSERT_NEXT(a_in_gives_out, s_tvalid && s_tready, m_tvalid)
  // An empty result register never stalls the input
  `OZM_ASSERT_IMPL(a_idle_ready, !m_tvalid, s_tready)
  // The same id twice in a row hits at the front
  `OZM_ASSERT_NEXT(a_repeat_front, (s_tvalid && s_tready) ##1 (s_tvalid && s_tready && $stable(s_tdata)), m_tvalid && m_tdata[3:0] == 4'b0001)

endmodule

bind open_zone_mru_tracker ozm_checker u_ozm_checker (.*);
